### rtl/core/rbu_pkg.sv
// Shared types and constants for the RGB565 Bresenham upscaler.
`default_nettype none

package rbu_pkg;

  localparam int unsigned PixWordW = 32;
  localparam int unsigned RowW     = 8;
  localparam int unsigned PairsPerGroup = 5;
  localparam int unsigned BeatW    = 3;

  localparam logic [PixWordW-1:0] PixMask = 32'hF7DE_F7DE;
  localparam logic [BeatW-1:0]    LastBeat = BeatW'(PairsPerGroup - 1);

  // One classified group: eight masked (and maybe blended) pixels plus row tags.
  typedef struct packed {
    logic [RowW-1:0]     out_row;
    logic [RowW-1:0]     src_row;
    logic [PixWordW-1:0] gh;
    logic [PixWordW-1:0] ef;
    logic [PixWordW-1:0] cd;
    logic [PixWordW-1:0] ab;
  } group_t;

endpackage

`default_nettype wire

### rtl/core/rbu_front.sv
// Front end: accepts source groups, blends rows vertically and steps row counters.
`default_nettype none

module rbu_front #(
  parameter int unsigned OUT_HEIGHT     = 240,
  parameter int unsigned GROUPS_PER_ROW = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [7:0]           vert_scale_i,
  input  wire logic                 in_valid_i,
  input  wire logic [255:0]         in_data_i,
  input  wire logic                 q_full_i,
  output logic                      in_ready_o,
  output logic                      push_o,
  output rbu_pkg::group_t           push_group_o
);
  import rbu_pkg::*;

  localparam int unsigned GrpW = (GROUPS_PER_ROW > 1) ? $clog2(GROUPS_PER_ROW) : 1;
  localparam logic [GrpW-1:0] GrpLast   = GrpW'(GROUPS_PER_ROW - 1);
  localparam logic [7:0]      HeightC   = 8'(OUT_HEIGHT);
  localparam logic [7:0]      HalfC     = 8'(OUT_HEIGHT / 2);
  localparam logic [7:0]      LastRowC  = 8'(OUT_HEIGHT - 1);

  function automatic logic [PixWordW-1:0] blend(input logic [PixWordW-1:0] up,
                                                 input logic [PixWordW-1:0] down);
    logic [PixWordW-1:0] s;
    s = ((up & PixMask) >> 1) + ((down & PixMask) >> 1);
    return s & PixMask;
  endfunction

  logic [7:0]      err_q, err_d;
  logic [7:0]      src_q, src_d;
  logic [7:0]      orow_q, orow_d;
  logic [GrpW-1:0] grp_q, grp_d;

  logic            accept;
  logic            do_blend;
  logic [7:0]      step;
  logic [8:0]      err_sum;
  logic [PixWordW-1:0] ab, cd, ef, gh;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign do_blend   = (err_q >= HalfC);

  always_comb begin
    ab = in_data_i[31:0]    & PixMask;
    cd = in_data_i[63:32]   & PixMask;
    ef = in_data_i[95:64]   & PixMask;
    gh = in_data_i[127:96]  & PixMask;
    if (do_blend) begin
      ab = blend(ab, in_data_i[159:128]);
      cd = blend(cd, in_data_i[191:160]);
      ef = blend(ef, in_data_i[223:192]);
      gh = blend(gh, in_data_i[255:224]);
    end
  end

  assign push_o               = accept;
  assign push_group_o.ab      = ab;
  assign push_group_o.cd      = cd;
  assign push_group_o.ef      = ef;
  assign push_group_o.gh      = gh;
  assign push_group_o.src_row = src_q;
  assign push_group_o.out_row = orow_q;

  // Clamp the scale so one subtraction brings the error back in range.
  assign step    = (vert_scale_i > HeightC) ? HeightC : vert_scale_i;
  assign err_sum = {1'b0, err_q} + {1'b0, step};

  always_comb begin
    err_d  = err_q;
    src_d  = src_q;
    orow_d = orow_q;
    grp_d  = grp_q;
    if (accept) begin
      if (grp_q == GrpLast) begin
        grp_d = '0;
        if (err_sum >= {1'b0, HeightC}) begin
          err_d = 8'(err_sum - {1'b0, HeightC});
          src_d = src_q + 8'd1;
        end else begin
          err_d = err_sum[7:0];
        end
        if (orow_q == LastRowC) begin
          orow_d = '0;
          src_d  = '0;
          err_d  = '0;
        end else begin
          orow_d = orow_q + 8'd1;
        end
      end else begin
        grp_d = grp_q + GrpW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q  <= '0;
      src_q  <= '0;
      orow_q <= '0;
      grp_q  <= '0;
    end else begin
      err_q  <= err_d;
      src_q  <= src_d;
      orow_q <= orow_d;
      grp_q  <= grp_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rbu_queue.sv
// Two-entry queue of classified groups between the front and back ends.
`default_nettype none

module rbu_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rbu_pkg::group_t push_group_i,
  input  wire logic            pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output rbu_pkg::group_t      head_o
);
  import rbu_pkg::*;

  group_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_group_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rbu_back.sv
// Back end: widens each group from eight to ten pixels and sends five pixel pairs.
`default_nettype none

module rbu_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire rbu_pkg::group_t q_head_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [47:0]          out_data_o,
  output logic                 out_last_o
);
  import rbu_pkg::*;

  logic [BeatW-1:0]    beat_q, beat_d;
  logic                valid_q, valid_d;
  logic [47:0]         data_q;
  logic                last_q;
  logic                load;
  logic [15:0]         mid_bc, mid_fg;
  logic [PixWordW-1:0] pair;

  // Interpolated pixels between b,c and between f,g.
  assign mid_bc = {1'b0, q_head_i.ab[31:17]} + {1'b0, q_head_i.cd[15:1]};
  assign mid_fg = {1'b0, q_head_i.ef[31:17]} + {1'b0, q_head_i.gh[15:1]};

  always_comb begin
    unique case (beat_q)
      3'd0:    pair = q_head_i.ab;
      3'd1:    pair = {q_head_i.cd[15:0], mid_bc};
      3'd2:    pair = {q_head_i.ef[15:0], q_head_i.cd[31:16]};
      3'd3:    pair = {mid_fg, q_head_i.ef[31:16]};
      default: pair = q_head_i.gh;
    endcase
  end

  assign load    = ~valid_q | out_ready_i;
  assign q_pop_o = load & q_valid_i & (beat_q == LastBeat);

  always_comb begin
    beat_d  = beat_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = q_valid_i;
      if (q_valid_i) begin
        beat_d = (beat_q == LastBeat) ? '0 : beat_q + BeatW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && q_valid_i) begin
      data_q <= {q_head_i.out_row, q_head_i.src_row, pair};
      last_q <= (beat_q == LastBeat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      beat_q  <= beat_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

### rtl/core/rgb565_bresenham_upscaler.sv
// Top level of the RGB565 8-to-10 upscaler with Bresenham vertical stepping.
//
//  port group   dir  width  carries
//  s_axis_*     in   256    one group: eight source pixels and the eight below
//  m_axis_*     out  48     one pixel pair with its source and output row
//  APB          in   32     vertical scale register at byte address 0
//
// Each accepted item yields five pairs, one per cycle while m_axis_tready is
// high; the five beats of the back end set the sustained item rate. The first
// pair of an item passes through the queue and the back end's output register
// before it is offered. A two-entry queue lets the front end run ahead of the
// back end. A stall on m_axis fills the queue, then drops s_axis_tready. Reset
// clears all counters and the queue; the scale register returns to 192.
`default_nettype none

module rgb565_bresenham_upscaler #(
  parameter int unsigned OUT_HEIGHT     = 240,
  parameter int unsigned GROUPS_PER_ROW = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // [63:0] top_low_pixels, [127:64] top_high_pixels,
  // [191:128] below_low_pixels, [255:192] below_high_pixels
  input  wire logic [255:0] s_axis_tdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] pixel_pair, [39:32] source_row, [47:40] output_row
  output logic [47:0]       m_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic              m_axis_tlast,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import rbu_pkg::*;

  localparam logic [7:0] ScaleReset = 8'd192;

  logic [7:0] scale_q;
  logic       cfg_wr;
  logic       sel_scale;

  logic       push;
  group_t     push_group;
  logic       q_full, q_valid, q_pop;
  group_t     q_head;

  assign pready    = 1'b1;
  assign sel_scale = (paddr[2] == 1'b0);
  assign cfg_wr    = psel & penable & pwrite & sel_scale;
  assign prdata    = sel_scale ? {24'd0, scale_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
    end else if (cfg_wr) begin
      scale_q <= pwdata[7:0];
    end
  end

  rbu_front #(
    .OUT_HEIGHT     (OUT_HEIGHT),
    .GROUPS_PER_ROW (GROUPS_PER_ROW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vert_scale_i   (scale_q),
    .in_valid_i     (s_axis_tvalid),
    .in_data_i      (s_axis_tdata),
    .q_full_i       (q_full),
    .in_ready_o     (s_axis_tready),
    .push_o         (push),
    .push_group_o   (push_group)
  );

  rbu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_group_i (push_group),
    .pop_i        (q_pop),
    .full_o       (q_full),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  rbu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire
